FILE: design/hts_pkg.sv
// Shared types and constants of the HTML tag strip filter.
`default_nettype none

package hts_pkg;

  // Depth of the pending whitespace buffer.
  localparam int PENDING_DEPTH = 32;
  // Pending bytes that may stay held while a partial entity match waits.
  localparam int PEND_CAP = (PENDING_DEPTH >= 4) ? (PENDING_DEPTH - 4) : 0;
  localparam int PCNT_W = $clog2(PENDING_DEPTH + 1);
  localparam int PPTR_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  // Command queue between front and back; the depth is a power of two.
  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW = $clog2(CQ_DEPTH);
  localparam int CQ_CW = $clog2(CQ_DEPTH + 1);

  // Characters that steer the front.
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_PUT,
    CMD_RESERVE
  } cmd_kind_t;

  // One command from the front to the back.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  ch;
    logic        item_end;
    logic        text_last;
  } cmd_t;

  // Position relative to markup tags.
  typedef enum logic [1:0] {
    TAG_OUT,
    TAG_IN,
    TAG_QUOTE
  } tag_mode_t;

  // Phases of the front.
  typedef enum logic [1:0] {
    FP_IDLE,
    FP_HELD1,
    FP_MAIN,
    FP_HELD2
  } front_phase_t;

  // States of the back.
  typedef enum logic [1:0] {
    BS_IDLE,
    BS_POP,
    BS_CHAR,
    BS_FIN
  } back_state_t;

  // Reason for taking bytes out of the pending buffer.
  typedef enum logic [1:0] {
    POP_SPILL1,
    POP_FLUSH,
    POP_RESV
  } pop_kind_t;

endpackage

`default_nettype wire

FILE: design/hts_cmd_fifo.sv
// Short command queue between the front and the back.
`default_nettype none

module hts_cmd_fifo
  import hts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  cmd_t      push_data,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_data
);

  cmd_t             q_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CQ_CW-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  // Handshake and pointer updates.
  always_comb begin
    push_ready = (cnt_r != CQ_CW'(CQ_DEPTH));
    pop_valid  = (cnt_r != '0);
    pop_data   = q_r[rd_ptr_r];
    do_push    = push_valid && push_ready;
    do_pop     = pop_valid && pop_ready;
    wr_ptr_nxt = do_push ? (wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? (rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: design/hts_front.sv
// Front end: tag tracking, entity matching and command generation.
`default_nettype none

module hts_front
  import hts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            cmd_valid,
  input  wire logic       cmd_ready,
  output cmd_t            cmd
);

  // Letter of the "&nbsp;" pattern at a given position.
  function automatic logic [7:0] entity_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h26;
      3'd1:    c = 8'h6E;
      3'd2:    c = 8'h62;
      3'd3:    c = 8'h73;
      3'd4:    c = 8'h70;
      default: c = 8'h3B;
    endcase
    return c;
  endfunction

  // Byte k of a broken match: "&amp;" followed by the held pattern letters.
  function automatic logic [7:0] held_char(input logic [3:0] k);
    logic [7:0] c;
    unique case (k)
      4'd0:    c = 8'h26;
      4'd1:    c = 8'h61;
      4'd2:    c = 8'h6D;
      4'd3:    c = 8'h70;
      4'd4:    c = 8'h3B;
      4'd5:    c = 8'h6E;
      4'd6:    c = 8'h62;
      4'd7:    c = 8'h73;
      4'd8:    c = 8'h70;
      default: c = 8'h3B;
    endcase
    return c;
  endfunction

  front_phase_t phase_r, phase_nxt;
  tag_mode_t    tag_mode_r, tag_mode_nxt;
  logic [2:0]   match_len_r, match_len_nxt;
  logic [3:0]   k_r, k_nxt;
  logic [2:0]   held1_len_r, held2_len_r;
  cmd_kind_t    main_kind_r;
  logic [7:0]   main_ch_r;
  logic         held2_r, last_r;

  // Classification of the offered byte.
  tag_mode_t    tag_step;
  logic         feed, cont, broken, held2;
  logic [2:0]   ml_new;
  cmd_kind_t    kind_new;
  logic [7:0]   ch_new;
  logic         accept;
  logic         held1_done, held2_done;

  always_comb begin
    unique case (tag_mode_r)
      TAG_OUT:   tag_step = (in_byte == CH_LT) ? TAG_IN : TAG_OUT;
      TAG_QUOTE: tag_step = (in_byte == CH_QUOTE) ? TAG_IN : TAG_QUOTE;
      default: begin
        if (in_byte == CH_QUOTE) begin
          tag_step = TAG_QUOTE;
        end else if (in_byte == CH_GT) begin
          tag_step = TAG_OUT;
        end else begin
          tag_step = TAG_IN;
        end
      end
    endcase

    feed   = (tag_mode_r == TAG_OUT) && (in_byte != CH_LT);
    cont   = feed && (match_len_r != '0) && (in_byte == entity_char(match_len_r));
    broken = feed && (match_len_r != '0) && !cont;

    kind_new = CMD_NOP;
    ch_new   = in_byte;
    ml_new   = match_len_r;
    if (!feed) begin
      kind_new = CMD_NOP;
    end else if (cont) begin
      if (match_len_r == 3'd5) begin
        kind_new = CMD_PUT;
        ch_new   = CH_SP;
        ml_new   = '0;
      end else begin
        ml_new = match_len_r + 1'b1;
      end
    end else if (in_byte == CH_AMP) begin
      kind_new = CMD_RESERVE;
      ml_new   = 3'd1;
    end else begin
      kind_new = CMD_PUT;
      ch_new   = (in_byte == CH_NL) ? CH_SP : in_byte;
      ml_new   = '0;
    end
    held2 = in_last && (ml_new != '0);
  end

  // Phase register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= FP_IDLE;
      tag_mode_r  <= TAG_OUT;
      match_len_r <= '0;
    end else begin
      phase_r     <= phase_nxt;
      tag_mode_r  <= tag_mode_nxt;
      match_len_r <= match_len_nxt;
    end
  end

  // Details of the accepted request and the held-sequence counter.
  always_ff @(posedge clk) begin
    k_r <= k_nxt;
    if (accept) begin
      held1_len_r <= match_len_r;
      held2_len_r <= ml_new;
      main_kind_r <= kind_new;
      main_ch_r   <= ch_new;
      held2_r     <= held2;
      last_r      <= in_last;
    end
  end

  // Next phase and command output.
  always_comb begin
    in_ready      = (phase_r == FP_IDLE);
    accept        = in_valid && in_ready;
    phase_nxt     = phase_r;
    tag_mode_nxt  = tag_mode_r;
    match_len_nxt = match_len_r;
    k_nxt         = k_r;
    held1_done    = (k_r == ({1'b0, held1_len_r} + 4'd3));
    held2_done    = (k_r == ({1'b0, held2_len_r} + 4'd3));
    cmd_valid     = 1'b0;
    cmd.kind      = CMD_PUT;
    cmd.ch        = held_char(k_r);
    cmd.item_end  = 1'b0;
    cmd.text_last = last_r;

    unique case (phase_r)
      FP_IDLE: begin
        if (accept) begin
          tag_mode_nxt  = in_last ? TAG_OUT : tag_step;
          match_len_nxt = in_last ? 3'd0 : ml_new;
          k_nxt         = '0;
          phase_nxt     = broken ? FP_HELD1 : FP_MAIN;
        end
      end
      FP_HELD1: begin
        cmd_valid = 1'b1;
        if (cmd_ready) begin
          if (held1_done) begin
            k_nxt     = '0;
            phase_nxt = FP_MAIN;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      FP_MAIN: begin
        cmd_valid    = 1'b1;
        cmd.kind     = main_kind_r;
        cmd.ch       = main_ch_r;
        cmd.item_end = !held2_r;
        if (cmd_ready) begin
          k_nxt     = '0;
          phase_nxt = held2_r ? FP_HELD2 : FP_IDLE;
        end
      end
      default: begin
        cmd_valid    = 1'b1;
        cmd.item_end = held2_done;
        if (cmd_ready) begin
          if (held2_done) begin
            phase_nxt = FP_IDLE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/hts_back.sv
// Back end: pending whitespace buffer, result hold stage and output register.
`default_nettype none

module hts_back
  import hts_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [7:0] out_byte,
  output logic      out_has_byte,
  output logic      out_run_end,
  output logic      out_text_end,
  output logic      out_spill
);

  // C-locale whitespace: space and tab through carriage return.
  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic [PPTR_W-1:0] ptr_inc(input logic [PPTR_W-1:0] p);
    logic [PPTR_W-1:0] q;
    if (p == PPTR_W'(PENDING_DEPTH - 1)) begin
      q = '0;
    end else begin
      q = p + 1'b1;
    end
    return q;
  endfunction

  back_state_t       state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  pop_kind_t         pop_kind_r, pop_kind_nxt;
  logic              seen_r, seen_nxt;
  logic [PCNT_W-1:0] cnt_r, cnt_nxt;
  logic [PPTR_W-1:0] head_r, head_nxt;
  logic [PPTR_W-1:0] tail_r, tail_nxt;
  logic              hold_valid_r, hold_valid_nxt;
  logic [7:0]        hold_byte_r, hold_byte_nxt;
  logic              hold_spill_r, hold_spill_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_has_r, out_has_nxt;
  logic              out_run_r, out_run_nxt;
  logic              out_text_r, out_text_nxt;
  logic              out_spill_r, out_spill_nxt;
  logic              out_load;

  // Pending buffer memory.
  logic [7:0]        mem [PENDING_DEPTH];
  logic [7:0]        rd_data_r;
  logic              mem_we, rd_en;
  logic [PPTR_W-1:0] mem_waddr, rd_addr;
  logic [7:0]        mem_wdata;

  // Work requests inside a state.
  logic       do_emit, do_fin, do_direct, do_clear;
  logic [7:0] emit_byte;
  logic       emit_spill;
  logic       out_free, emit_ok, fin_ok;
  logic       ws_in;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // State and command execution.
  always_comb begin
    out_free   = !out_valid_r || out_ready;
    emit_ok    = !hold_valid_r || out_free;
    fin_ok     = (!hold_valid_r && !cmd_r.text_last) || out_free;
    cmd_ready  = (state_r == BS_IDLE);
    ws_in      = is_ws(cmd.ch);

    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    pop_kind_nxt = pop_kind_r;
    seen_nxt     = seen_r;
    cnt_nxt      = cnt_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    mem_we       = 1'b0;
    mem_waddr    = tail_r;
    mem_wdata    = cmd_r.ch;
    rd_en        = 1'b0;
    rd_addr      = head_r;
    do_emit      = 1'b0;
    do_fin       = 1'b0;
    do_direct    = 1'b0;
    do_clear     = 1'b0;
    emit_byte    = rd_data_r;
    emit_spill   = 1'b0;

    unique case (state_r)
      BS_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt = cmd;
          // Default: nothing to emit, finish the request if needed.
          if (cmd.item_end && (hold_valid_r || cmd.text_last)) begin
            state_nxt = BS_FIN;
          end
          unique case (cmd.kind)
            CMD_PUT: begin
              if (ws_in) begin
                if (seen_r && (cnt_r == PCNT_W'(PENDING_DEPTH))) begin
                  rd_en        = 1'b1;
                  pop_kind_nxt = POP_SPILL1;
                  state_nxt    = BS_POP;
                end else if (seen_r) begin
                  mem_we    = 1'b1;
                  mem_wdata = cmd.ch;
                  tail_nxt  = ptr_inc(tail_r);
                  cnt_nxt   = cnt_r + 1'b1;
                end
              end else if (cnt_r != '0) begin
                rd_en        = 1'b1;
                pop_kind_nxt = POP_FLUSH;
                state_nxt    = BS_POP;
              end else begin
                state_nxt = BS_CHAR;
              end
            end
            CMD_RESERVE: begin
              if (cnt_r > PCNT_W'(PEND_CAP)) begin
                rd_en        = 1'b1;
                pop_kind_nxt = POP_RESV;
                state_nxt    = BS_POP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      BS_POP: begin
        // Emit the oldest pending byte, read earlier through the registered read port.
        if (emit_ok) begin
          do_emit    = 1'b1;
          emit_byte  = rd_data_r;
          emit_spill = (pop_kind_r != POP_FLUSH);
          head_nxt   = ptr_inc(head_r);
          cnt_nxt    = cnt_r - 1'b1;
          rd_addr    = ptr_inc(head_r);
          unique case (pop_kind_r)
            POP_SPILL1: begin
              mem_we    = 1'b1;
              mem_wdata = cmd_r.ch;
              tail_nxt  = ptr_inc(tail_r);
              cnt_nxt   = cnt_r;
              state_nxt = cmd_r.item_end ? BS_FIN : BS_IDLE;
            end
            POP_FLUSH: begin
              if (cnt_r > PCNT_W'(1)) begin
                rd_en = 1'b1;
              end else begin
                state_nxt = BS_CHAR;
              end
            end
            default: begin
              if (cnt_r > PCNT_W'(PEND_CAP + 1)) begin
                rd_en = 1'b1;
              end else begin
                state_nxt = cmd_r.item_end ? BS_FIN : BS_IDLE;
              end
            end
          endcase
        end
      end
      BS_CHAR: begin
        // A lone result of the request goes straight to the output register.
        if (cmd_r.item_end && !hold_valid_r) begin
          if (out_free) begin
            do_direct = 1'b1;
            seen_nxt  = 1'b1;
            do_clear  = cmd_r.text_last;
            state_nxt = BS_IDLE;
          end
        end else if (emit_ok) begin
          do_emit   = 1'b1;
          emit_byte = cmd_r.ch;
          seen_nxt  = 1'b1;
          state_nxt = cmd_r.item_end ? BS_FIN : BS_IDLE;
        end
      end
      default: begin
        if (fin_ok) begin
          do_fin    = 1'b1;
          do_clear  = cmd_r.text_last;
          state_nxt = BS_IDLE;
        end
      end
    endcase

    // End of text: drop leading-space state and trailing whitespace.
    if (do_clear) begin
      seen_nxt = 1'b0;
      cnt_nxt  = '0;
      head_nxt = '0;
      tail_nxt = '0;
    end
  end

  // Hold stage and output register.
  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_byte_nxt  = hold_byte_r;
    hold_spill_nxt = hold_spill_r;
    out_load       = 1'b0;
    out_byte_nxt   = hold_byte_r;
    out_has_nxt    = 1'b1;
    out_run_nxt    = 1'b0;
    out_text_nxt   = 1'b0;
    out_spill_nxt  = hold_spill_r;

    if (do_emit) begin
      out_load       = hold_valid_r;
      hold_valid_nxt = 1'b1;
      hold_byte_nxt  = emit_byte;
      hold_spill_nxt = emit_spill;
    end else if (do_fin) begin
      out_load     = 1'b1;
      out_run_nxt  = 1'b1;
      out_text_nxt = cmd_r.text_last;
      if (hold_valid_r) begin
        hold_valid_nxt = 1'b0;
      end else begin
        out_byte_nxt  = '0;
        out_has_nxt   = 1'b0;
        out_spill_nxt = 1'b0;
      end
    end else if (do_direct) begin
      out_load      = 1'b1;
      out_byte_nxt  = cmd_r.ch;
      out_run_nxt   = 1'b1;
      out_text_nxt  = cmd_r.text_last;
      out_spill_nxt = 1'b0;
    end

    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BS_IDLE;
      seen_r       <= 1'b0;
      cnt_r        <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      seen_r       <= seen_nxt;
      cnt_r        <= cnt_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    pop_kind_r   <= pop_kind_nxt;
    hold_byte_r  <= hold_byte_nxt;
    hold_spill_r <= hold_spill_nxt;
    if (out_load) begin
      out_byte_r  <= out_byte_nxt;
      out_has_r   <= out_has_nxt;
      out_run_r   <= out_run_nxt;
      out_text_r  <= out_text_nxt;
      out_spill_r <= out_spill_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_has_byte = out_has_r;
  assign out_run_end  = out_run_r;
  assign out_text_end = out_text_r;
  assign out_spill    = out_spill_r;

endmodule

`default_nettype wire

FILE: design/html_tag_strip_filter_unit.sv
// Top level of the HTML tag strip filter: front, command queue and back.
//
//   Channel | Ports                                     | Moves
//   in      | in_valid, in_ready, in_byte, in_last      | one raw text byte per request
//   out     | out_valid, out_ready, out_byte,           | one cleaned result per request
//           | out_has_byte, out_run_end, out_text_end,  |
//           | out_spill                                 |
//
// The front takes a byte and then writes 1 to 15 commands into the queue,
// one a cycle while the queue has room, and takes no new byte until the last
// is written; a broken entity match adds the escaped held sequence, and so
// does an entity open at text end. The back flushes or spills held whitespace
// bytes through the registered read port of the pending buffer and takes no
// new command until it is done. A stalled output register stops the back, a
// full queue stops the front. Synchronous reset clears all control state; the
// pending buffer needs no clearing pass.
`default_nettype none

module html_tag_strip_filter_unit
  import hts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_has_byte,
  output logic            out_run_end,
  output logic            out_text_end,
  output logic            out_spill
);

  logic fc_valid, fc_ready;
  cmd_t fc_cmd;
  logic bc_valid, bc_ready;
  cmd_t bc_cmd;

  hts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .cmd_valid (fc_valid),
    .cmd_ready (fc_ready),
    .cmd       (fc_cmd)
  );

  hts_cmd_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fc_valid),
    .push_ready (fc_ready),
    .push_data  (fc_cmd),
    .pop_valid  (bc_valid),
    .pop_ready  (bc_ready),
    .pop_data   (bc_cmd)
  );

  hts_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (bc_valid),
    .cmd_ready    (bc_ready),
    .cmd          (bc_cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_run_end  (out_run_end),
    .out_text_end (out_text_end),
    .out_spill    (out_spill)
  );

endmodule

`default_nettype wire
